// ----- rtl/hpd_pkg.sv -----
// Package for the hold-and-modify pixel decoder: widths, codes and the
// stage-1 control struct. No dependencies.
`timescale 1ns / 1ps

package hpd_pkg;

	localparam int PALETTE_DEPTH = 64;

	localparam int IDX_W   = 6;
	localparam int COLOR_W = 12;
	localparam int NIB_W   = 4;
	localparam int CODE_W  = 8;
	localparam int CHAN_W  = 8;

	// command field
	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_PIXEL   = 1'b1;

	// ham_mode register
	localparam logic MODE_HAM6 = 1'b0;
	localparam logic MODE_HAM8 = 1'b1;

	// action selected by code bits 7:6 (HAM8) or 5:4 (HAM6)
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_BLUE  = 2'd1;
	localparam logic [1:0] ACT_RED   = 2'd2;
	localparam logic [1:0] ACT_GREEN = 2'd3;

	typedef struct packed {
		logic              valid;
		logic              line_start;
		logic              in_range;
		logic [CODE_W-1:0] code;
	} hpd_s1_t;

	// 4-bit channel to 8 bits, nibble * 0x11
	function automatic logic [CHAN_W-1:0] expand(input logic [NIB_W-1:0] n);
		return {n, n};
	endfunction

endpackage

// ----- rtl/hpd_cmd_if.sv -----
// Input channel of the decoder: palette writes and pixel codes.
// Depends on hpd_pkg.
`timescale 1ns / 1ps

interface hpd_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [hpd_pkg::IDX_W-1:0]   palette_index;
	logic [hpd_pkg::COLOR_W-1:0] palette_color;
	logic [hpd_pkg::CODE_W-1:0]  pixel_code;
	logic                        line_start;

	modport source (output valid, command, palette_index, palette_color, pixel_code,
		line_start, input ready);
	modport sink (input valid, command, palette_index, palette_color, pixel_code,
		line_start, output ready);
endinterface

// ----- rtl/hpd_pixel_if.sv -----
// Output channel of the decoder: one 24-bit color per pixel transaction.
// Depends on hpd_pkg.
`timescale 1ns / 1ps

interface hpd_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [hpd_pkg::CHAN_W-1:0] red;
	logic [hpd_pkg::CHAN_W-1:0] green;
	logic [hpd_pkg::CHAN_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

// ----- rtl/hpd_cfg_if.sv -----
// Configuration write channel carrying the ham_mode register.
// No dependencies.
`timescale 1ns / 1ps

interface hpd_cfg_if;
	logic valid;
	logic ready;
	logic ham_mode;

	modport source (output valid, ham_mode, input ready);
	modport sink (input valid, ham_mode, output ready);
endinterface

// ----- rtl/hpd_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module hpd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/hpd_color_unit.sv -----
// Stage 1 of the decoder: applies the hold-and-modify action to the held
// color using the palette read data, and owns the output register.
// Depends on hpd_pkg and hpd_pixel_if.
`timescale 1ns / 1ps

module hpd_color_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ham_mode,
	input  hpd_pkg::hpd_s1_t            stage_s1,
	input  logic [hpd_pkg::COLOR_W-1:0] entry,
	output logic                        take,
	hpd_pixel_if.source                 pixel
);

	logic [hpd_pkg::CHAN_W-1:0] held_red_q, held_green_q, held_blue_q;
	logic [hpd_pkg::CHAN_W-1:0] red_q, green_q, blue_q;
	logic                       out_valid_q;

	logic [hpd_pkg::COLOR_W-1:0] ent;
	logic [hpd_pkg::CHAN_W-1:0]  base_r, base_g, base_b;
	logic [hpd_pkg::CHAN_W-1:0]  new_r, new_g, new_b;
	logic [1:0]                  act;
	logic                        nop;
	logic                        reload;
	logic [hpd_pkg::CODE_W-1:0]  code;

	assign code = stage_s1.code;

	always_comb begin
		if (ham_mode == hpd_pkg::MODE_HAM8) begin
			act = code[7:6];
			nop = 1'b0;
		end else begin
			act = code[5:4];
			nop = (code[7:6] != 2'b00);
		end
		reload = stage_s1.line_start || (!nop && act == hpd_pkg::ACT_LOAD);
		// read address was the coded entry on a load, entry 0 otherwise
		ent    = stage_s1.in_range ? entry : '0;
		base_r = reload ? hpd_pkg::expand(ent[11:8]) : held_red_q;
		base_g = reload ? hpd_pkg::expand(ent[7:4])  : held_green_q;
		base_b = reload ? hpd_pkg::expand(ent[3:0])  : held_blue_q;
		new_r  = base_r;
		new_g  = base_g;
		new_b  = base_b;
		if (!nop) begin
			case (act)
				hpd_pkg::ACT_BLUE: begin
					new_b = (ham_mode == hpd_pkg::MODE_HAM8) ? {code[5:0], base_b[1:0]}
						: hpd_pkg::expand(code[3:0]);
				end
				hpd_pkg::ACT_RED: begin
					new_r = (ham_mode == hpd_pkg::MODE_HAM8) ? {code[5:0], base_r[1:0]}
						: hpd_pkg::expand(code[3:0]);
				end
				hpd_pkg::ACT_GREEN: begin
					new_g = (ham_mode == hpd_pkg::MODE_HAM8) ? {code[5:0], base_g[1:0]}
						: hpd_pkg::expand(code[3:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign take = !out_valid_q || pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_red_q   <= '0;
			held_green_q <= '0;
			held_blue_q  <= '0;
			out_valid_q  <= 1'b0;
		end else if (take) begin
			out_valid_q <= stage_s1.valid;
			if (stage_s1.valid) begin
				held_red_q   <= new_r;
				held_green_q <= new_g;
				held_blue_q  <= new_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && stage_s1.valid) begin
			red_q   <= new_r;
			green_q <= new_g;
			blue_q  <= new_b;
		end
	end

	assign pixel.valid = out_valid_q;
	assign pixel.red   = red_q;
	assign pixel.green = green_q;
	assign pixel.blue  = blue_q;

endmodule

// ----- rtl/ham_pixel_decoder.sv -----
// Hold-and-modify pixel decoder.
//
// Channels: cmd carries palette writes (command 0) and pixel codes
// (command 1); pixel returns one red/green/blue result per pixel
// transaction, none for palette writes; cfg writes ham_mode (0 = HAM6,
// 1 = HAM8) and is always ready. Write cfg only while the block is idle.
// Throughput: one transaction per cycle while pixel.ready stays high. Each pixel
// does a single palette read (the coded entry on a load action, entry 0
// otherwise), so the one read port of the palette RAM sets the rate.
// Pipeline: a pixel accepted on cmd passes the RAM read register, then the
// output register, before it is valid on pixel.
// Reset: held color clears to zero, ham_mode to HAM6. Palette contents are
// undefined until written.
// Stall: while pixel.ready is low the result holds, one more pixel waits in
// stage 1, and cmd.ready drops until the output register drains.
// Depends on hpd_pkg, hpd_cmd_if, hpd_pixel_if, hpd_cfg_if, hpd_ram,
// hpd_color_unit.
`timescale 1ns / 1ps

module ham_pixel_decoder #(
	parameter int PALETTE_DEPTH = hpd_pkg::PALETTE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	hpd_cfg_if.sink     cfg,
	hpd_cmd_if.sink     cmd,
	hpd_pixel_if.source pixel
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam logic [hpd_pkg::IDX_W:0] DEPTH_L = (hpd_pkg::IDX_W + 1)'(PALETTE_DEPTH);

	logic                        ham_mode_q;
	logic                        accept;
	logic                        take;
	logic                        wr_en, rd_en;
	logic                        load;
	logic [hpd_pkg::IDX_W-1:0]   code_idx, rd_idx;
	logic [hpd_pkg::COLOR_W-1:0] rdata;

	logic                        valid_s1;
	logic                        line_start_s1;
	logic                        in_range_s1;
	logic [hpd_pkg::CODE_W-1:0]  code_s1;
	hpd_pkg::hpd_s1_t            stage_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ham_mode_q <= hpd_pkg::MODE_HAM6;
		end else if (cfg.valid) begin
			ham_mode_q <= cfg.ham_mode;
		end
	end

	assign cmd.ready = !valid_s1 || take;
	assign accept    = cmd.valid && cmd.ready;

	// entry picked by a load action; entry 0 serves the line-start reload
	always_comb begin
		if (ham_mode_q == hpd_pkg::MODE_HAM8) begin
			code_idx = cmd.pixel_code[5:0];
			load     = (cmd.pixel_code[7:6] == hpd_pkg::ACT_LOAD);
		end else begin
			code_idx = {2'b00, cmd.pixel_code[3:0]};
			load     = (cmd.pixel_code[7:4] == {2'b00, hpd_pkg::ACT_LOAD});
		end
		rd_idx = load ? code_idx : '0;
	end

	assign wr_en = accept && cmd.command == hpd_pkg::CMD_PALETTE
		&& ({1'b0, cmd.palette_index} < DEPTH_L);
	assign rd_en = accept && cmd.command == hpd_pkg::CMD_PIXEL;

	hpd_ram #(
		.WIDTH (hpd_pkg::COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd.palette_index[AW-1:0]),
		.wdata (cmd.palette_color),
		.re    (rd_en),
		.raddr (rd_idx[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			line_start_s1 <= cmd.line_start;
			in_range_s1   <= ({1'b0, rd_idx} < DEPTH_L);
			code_s1       <= cmd.pixel_code;
		end
	end

	assign stage_s1 = '{valid: valid_s1, line_start: line_start_s1,
		in_range: in_range_s1, code: code_s1};

	hpd_color_unit u_color (
		.clk      (clk),
		.arst_n   (arst_n),
		.ham_mode (ham_mode_q),
		.stage_s1 (stage_s1),
		.entry    (rdata),
		.take     (take),
		.pixel    (pixel)
	);

endmodule
